// ===== rtl/tvcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvcm_pkg
// Shared widths and constants for the tetrahedron volume pipeline.
// ----------------------------------------------------------------------------
package tvcm_pkg;
    localparam int COORD_BITS_DEF  = 20;
    localparam int VOLUME_BITS_DEF = 48;
    // sqrt(8 D^2 / 288) = |D| / 6
    localparam int CM_DIV   = 288;
    localparam int VOL_DIV  = CM_DIV / 48;
    // |D|/6 = (|D|/2)/3; reciprocals of 3, exact for operands below 2^17 and 2^19
    localparam int DIV3     = VOL_DIV / 2;
    localparam int RCP3_17  = ((1 << 17) + 1) / DIV3;
    localparam int RCP3_19  = ((1 << 19) + 1) / DIV3;
endpackage
`default_nettype wire

// ===== rtl/tvcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvcm_in_if / tvcm_out_if
// Valid/ready channels carrying the four points and the volume result.
// ----------------------------------------------------------------------------
interface tvcm_in_if #(parameter int COORD_BITS = 20);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z;
    logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
    modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface tvcm_out_if #(parameter int VOLUME_BITS = 48);
    logic valid;
    logic ready;
    logic [VOLUME_BITS-1:0] volume;
    logic degenerate;
    logic saturated;
    modport source (output valid, volume, degenerate, saturated, input ready);
    modport sink (input valid, volume, degenerate, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/tetrahedron_volume_cayley_menger_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tetrahedron_volume_cayley_menger_top
// Exact tetrahedron volume, floor(|D|/6), D the triple product of edges.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready channel, one item = four points (x, y, z each).
//   out : valid/ready channel, volume plus degenerate and saturated flags.
//   One result per item. Eight register stages: edge vectors, 2x2 products,
//   cofactors, triple products, sum and magnitude, 16-bit limbs of |D|/2 with
//   their residues mod 3, limb quotients by 3, saturation.
//   out.valid rises when the item reaches the saturation stage register.
//   Throughput is one item per cycle while out.ready stays high, set by the
//   stage registers (each holds at most one multiplier per lane).
//   Stall: every stage advances only when the stage after it is empty or
//   moving, so a held out.ready freezes the pipe without loss; in.ready
//   falls only when the first stage is full and cannot move.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module tetrahedron_volume_cayley_menger_top #(
    parameter int COORD_BITS  = tvcm_pkg::COORD_BITS_DEF,
    parameter int VOLUME_BITS = tvcm_pkg::VOLUME_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tvcm_in_if.sink   in,
    tvcm_out_if.source out
);
    import tvcm_pkg::*;

    localparam int DW = COORD_BITS + 1;      // edge component
    localparam int PW = 2 * DW;              // 2x2 product
    localparam int MW = PW + 1;              // cofactor
    localparam int TW = DW + MW;             // triple term
    localparam int SW = TW + 2;              // determinant D
    localparam int XW = SW - 1;              // |D|/2
    localparam int NL = (XW + 15) / 16;      // 16-bit limbs of |D|/2
    localparam int QW = NL * 16;
    localparam int NS = 8;

    // v mod 3 by the reciprocal of 3
    function automatic logic [1:0] mod3_limb(input logic [15:0] v);
        logic [32:0] p;
        logic [15:0] fq;
        logic [17:0] rm;
        p  = 33'(v) * 33'(RCP3_17);
        fq = p[32:17];
        rm = 18'(v) - 18'(fq) - 18'({fq, 1'b0});
        return rm[1:0];
    endfunction

    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = 3'(a) + 3'(b);
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    // floor((r * 2^16 + v) / 3), below 2^16 since r < 3
    function automatic logic [15:0] div3_limb(input logic [1:0] r, input logic [15:0] v);
        logic [35:0] p;
        p = 36'({r, v}) * 36'(RCP3_19);
        return p[34:19];
    endfunction

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = ~vld_reg[NS-1] | out.ready;
        for (int i = NS - 2; i >= 0; i--)
            adv[i] = ~vld_reg[i] | adv[i+1];
    end
    assign in.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in.valid;
            for (int i = 1; i < NS; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 1: edge vectors
    logic signed [DW-1:0] d_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_reg[0] <= DW'(in.p1_x) - DW'(in.p0_x);
            d_reg[1] <= DW'(in.p1_y) - DW'(in.p0_y);
            d_reg[2] <= DW'(in.p1_z) - DW'(in.p0_z);
            d_reg[3] <= DW'(in.p2_x) - DW'(in.p0_x);
            d_reg[4] <= DW'(in.p2_y) - DW'(in.p0_y);
            d_reg[5] <= DW'(in.p2_z) - DW'(in.p0_z);
            d_reg[6] <= DW'(in.p3_x) - DW'(in.p0_x);
            d_reg[7] <= DW'(in.p3_y) - DW'(in.p0_y);
            d_reg[8] <= DW'(in.p3_z) - DW'(in.p0_z);
        end
    end

    // stage 2: six minor products, first row carried
    logic signed [PW-1:0] pr_reg [6];
    logic signed [DW-1:0] a_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pr_reg[0] <= PW'(d_reg[4]) * PW'(d_reg[8]);
            pr_reg[1] <= PW'(d_reg[5]) * PW'(d_reg[7]);
            pr_reg[2] <= PW'(d_reg[3]) * PW'(d_reg[8]);
            pr_reg[3] <= PW'(d_reg[5]) * PW'(d_reg[6]);
            pr_reg[4] <= PW'(d_reg[3]) * PW'(d_reg[7]);
            pr_reg[5] <= PW'(d_reg[4]) * PW'(d_reg[6]);
            a_reg[0]  <= d_reg[0];
            a_reg[1]  <= d_reg[1];
            a_reg[2]  <= d_reg[2];
        end
    end

    // stage 3: cofactors
    logic signed [MW-1:0] m_reg [3];
    logic signed [DW-1:0] b_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            m_reg[0] <= MW'(pr_reg[0]) - MW'(pr_reg[1]);
            m_reg[1] <= MW'(pr_reg[2]) - MW'(pr_reg[3]);
            m_reg[2] <= MW'(pr_reg[4]) - MW'(pr_reg[5]);
            b_reg    <= a_reg;
        end
    end

    // stage 4: triple-product terms
    logic signed [TW-1:0] t_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[3])
            for (int i = 0; i < 3; i++)
                t_reg[i] <= TW'(b_reg[i]) * TW'(m_reg[i]);
    end

    // stage 5: magnitude of D, zero flag
    logic signed [SW-1:0] det;
    logic [SW-1:0] mag_reg;
    logic zero_reg;
    assign det = SW'(t_reg[0]) - SW'(t_reg[1]) + SW'(t_reg[2]);
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            mag_reg  <= det[SW-1] ? SW'(-det) : det;
            zero_reg <= (det == '0);
        end
    end

    // stage 6: |D|/2 split into 16-bit limbs, each limb mod 3
    logic [QW-1:0] half_mag;
    logic [15:0] lb_reg [NL];
    logic [1:0] lm_reg [NL];
    logic zero6_reg;
    assign half_mag = QW'(mag_reg[SW-1:1]);
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int i = 0; i < NL; i++)
            begin
                lb_reg[i] <= half_mag[16*i +: 16];
                lm_reg[i] <= mod3_limb(half_mag[16*i +: 16]);
            end
            zero6_reg <= zero_reg;
        end
    end

    // stage 7: limb quotients; 2^16 = 1 mod 3, so the remainder entering a
    // limb is the sum of the limbs above it, mod 3
    logic [1:0] rin [NL];
    logic [QW-1:0] q_reg;
    logic zero7_reg;
    always_comb
    begin
        rin[NL-1] = 2'd0;
        for (int i = NL - 2; i >= 0; i--)
            rin[i] = add_mod3(rin[i+1], lm_reg[i+1]);
    end
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int i = 0; i < NL; i++)
                q_reg[16*i +: 16] <= div3_limb(rin[i], lb_reg[i]);
            zero7_reg <= zero6_reg;
        end
    end

    // stage 8: saturate
    logic over;
    logic [VOLUME_BITS-1:0] vol_reg;
    logic deg_reg, sat_reg;
    assign over = (QW > VOLUME_BITS) ? ((q_reg >> VOLUME_BITS) != '0) : 1'b0;
    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            vol_reg <= over ? '1 : VOLUME_BITS'(q_reg);
            deg_reg <= zero7_reg;
            sat_reg <= over;
        end
    end

    assign out.valid      = vld_reg[NS-1];
    assign out.volume     = vol_reg;
    assign out.degenerate = deg_reg;
    assign out.saturated  = sat_reg;
endmodule
`default_nettype wire
